@@ hw/rtl/wtcfs_pkg.sv @@
// Package: types and constants for the weighted three-class FIFO scheduler.
`default_nettype none
package wtcfs_pkg;
	localparam int NUM_CLASSES = 3;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_SERVE  = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DUP       = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_INVALID   = 3'd4,
		ST_EMPTY     = 3'd5,
		ST_RENEWED   = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		REG_UPPER = 3'd0,
		REG_LOWER = 3'd1,
		REG_W0    = 3'd2,
		REG_W1    = 3'd3,
		REG_W2    = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		FSM_IDLE  = 2'd0,
		FSM_SCAN  = 2'd1,
		FSM_SHIFT = 2'd2,
		FSM_OUT   = 2'd3
	} fsm_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  age_key;
		logic [31:0] person_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        served_valid;
		logic [31:0] served_id;
		logic [1:0]  served_class;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture command, start scan
		logic step;   // one scan / shift step
		logic finish; // commit result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_shift; // command needs compaction
		logic scan_done;
		logic shift_done;
	} dp_stat_t;
endpackage
`default_nettype wire

@@ hw/rtl/wtcfs_ctrl.sv @@
// Controller state machine of the scheduler.
`default_nettype none
module wtcfs_ctrl
	import wtcfs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);
	fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				cmd.step = 1'b1;
				if (stat.scan_done) state_d = stat.need_shift ? FSM_SHIFT : FSM_OUT;
				if (stat.scan_done && !stat.need_shift) cmd.finish = 1'b1;
			end
			FSM_SHIFT: begin
				cmd.step = 1'b1;
				if (stat.shift_done) begin
					cmd.finish = 1'b1;
					state_d    = FSM_OUT;
				end
			end
			FSM_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ hw/rtl/wtcfs_dp.sv @@
// Datapath: queue memory, fill and credit registers, serial scan and compaction.
`default_nettype none
module wtcfs_dp
	import wtcfs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire in_item_t    in_item,
	input  wire dp_cmd_t     cmd,
	output dp_stat_t         stat,
	output out_item_t        out_item,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = PW + 2;

	logic [ID_WIDTH-1:0] mem [NUM_CLASSES * (2 ** PW)];

	logic [7:0] upper_q, lower_q;
	logic [2:0] weight_q [NUM_CLASSES];
	logic [FW-1:0] fill_q [NUM_CLASSES];
	logic [2:0] credit_q [NUM_CLASSES];

	logic [1:0]          kind_q;
	logic [1:0]          cls_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [FW-1:0]       pos_q;
	logic                hit_q;
	logic                rd_pend_q;
	logic [2:0]          status_q;
	logic                sv_q;
	logic [ID_WIDTH-1:0] sid_q;
	logic [FW-1:0]       wr_pos_q;
	logic                shifting_q;
	logic [ID_WIDTH-1:0] rdata_q;

	// command decode at load
	logic [1:0] in_cls;
	logic       all_empty;
	logic [1:0] srv_cls;
	logic       srv_any;
	logic [ID_WIDTH-1:0] in_id;

	assign in_id = ID_WIDTH'(in_item.person_id);

	always_comb begin
		if (in_item.age_key > upper_q) in_cls = 2'd0;
		else if (in_item.age_key > lower_q) in_cls = 2'd1;
		else in_cls = 2'd2;
		all_empty = (fill_q[0] == '0) && (fill_q[1] == '0) && (fill_q[2] == '0);
		srv_any = 1'b0;
		srv_cls = 2'd0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (fill_q[c] != '0 && credit_q[c] < weight_q[c]) begin
				srv_any = 1'b1;
				srv_cls = 2'(c);
			end
		end
	end

	logic [FW-1:0] cur_fill;
	assign cur_fill = fill_q[cls_q];

	logic full_c;
	assign full_c = cur_fill >= FW'(QUEUE_DEPTH);

	// while compacting, the read address runs two entries ahead of the write
	logic [AW-1:0] rd_addr;
	logic [FW-1:0] rd_pos;
	always_comb begin
		rd_pos  = shifting_q ? FW'(wr_pos_q + 2'd2) : pos_q;
		rd_addr = {cls_q, rd_pos[PW-1:0]};
	end

	logic match;
	assign match = rd_pend_q && (rdata_q == id_q);

	logic scan_active;
	assign scan_active = cmd.step && !shifting_q;

	// scan: issue reads for pos below fill, compare against the registered read data
	logic scan_end;
	assign scan_end = (kind_q == KIND_INSERT || kind_q == KIND_REMOVE) && status_q == ST_OK
		&& !hit_q && !match ? (pos_q >= cur_fill && !rd_pend_q) : 1'b1;

	logic found;
	assign found = hit_q || match;

	logic need_shift_c;
	assign need_shift_c = status_q == ST_OK && (kind_q == KIND_SERVE ? sv_q
		: (kind_q == KIND_REMOVE && found));

	always_comb begin
		stat.scan_done  = scan_active && scan_end;
		stat.need_shift = need_shift_c;
		stat.shift_done = shifting_q && cmd.step && (FW'(wr_pos_q + 1'b1) >= cur_fill);
	end

	// serve needs head read: rd_pend set at load via pos 0
	logic [FW-1:0] match_pos;
	assign match_pos = FW'(pos_q - 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rdata_q <= mem[{(in_item.kind == KIND_SERVE) ? srv_cls : in_cls, {PW{1'b0}}}];
		end else begin
			rdata_q <= mem[rd_addr];
		end
		if (shifting_q && cmd.step && !(FW'(wr_pos_q + 1'b1) >= cur_fill))
			mem[{cls_q, wr_pos_q[PW-1:0]}] <= rdata_q;
		if (cmd.finish && kind_q == KIND_INSERT && status_q == ST_OK && !found && !full_c)
			mem[{cls_q, cur_fill[PW-1:0]}] <= id_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= in_item.kind;
			id_q      <= in_id;
			pos_q     <= '0;
			hit_q     <= 1'b0;
			rd_pend_q <= 1'b0;
			sv_q      <= 1'b0;
			shifting_q <= 1'b0;
			sid_q     <= '0;
			cls_q     <= in_cls;
			status_q  <= ST_OK;
			unique case (in_item.kind)
				KIND_INSERT: if (in_item.age_key == '0) status_q <= ST_INVALID;
				KIND_SERVE: begin
					if (srv_any) begin
						sv_q  <= 1'b1;
						cls_q <= srv_cls;
						rd_pend_q <= 1'b1;
						pos_q <= FW'(1);
					end else if (all_empty) status_q <= ST_EMPTY;
					else status_q <= ST_RENEWED;
				end
				KIND_REMOVE: begin
					if (all_empty) status_q <= ST_EMPTY;
					else if (in_item.age_key == '0) status_q <= ST_INVALID;
				end
				default: status_q <= ST_INVALID;
			endcase
		end else if (scan_active) begin
			if (kind_q == KIND_SERVE) begin
				if (rd_pend_q) begin
					sid_q     <= rdata_q;
					rd_pend_q <= 1'b0;
					wr_pos_q  <= '0;
					shifting_q <= 1'b1;
				end
			end else if (!scan_end) begin
				rd_pend_q <= pos_q < cur_fill;
				if (pos_q < cur_fill) pos_q <= FW'(pos_q + 1'b1);
			end else begin
				if (match) begin
					hit_q <= 1'b1;
					wr_pos_q <= match_pos;
				end
				rd_pend_q <= 1'b0;
				if (kind_q == KIND_INSERT && status_q == ST_OK) begin
					if (found) status_q <= ST_DUP;
					else if (full_c) status_q <= ST_FULL;
				end else if (kind_q == KIND_REMOVE && status_q == ST_OK && !found)
					status_q <= ST_NOT_FOUND;
				if (kind_q == KIND_REMOVE && found) shifting_q <= 1'b1;
			end
		end else if (shifting_q && cmd.step) begin
			wr_pos_q <= FW'(wr_pos_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= 8'd55;
			lower_q <= 8'd40;
			weight_q[0] <= 3'd3;
			weight_q[1] <= 3'd2;
			weight_q[2] <= 3'd1;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				fill_q[c]   <= '0;
				credit_q[c] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_UPPER: upper_q     <= cfg_data;
					REG_LOWER: lower_q     <= cfg_data;
					REG_W0:    weight_q[0] <= cfg_data[2:0];
					REG_W1:    weight_q[1] <= cfg_data[2:0];
					REG_W2:    weight_q[2] <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (cmd.finish && status_q == ST_OK) begin
				if (kind_q == KIND_INSERT && !found) begin
					if (!full_c) fill_q[cls_q] <= FW'(cur_fill + 1'b1);
				end else if (kind_q == KIND_SERVE || (kind_q == KIND_REMOVE && found)) begin
					fill_q[cls_q] <= FW'(cur_fill - 1'b1);
					if (kind_q == KIND_SERVE) credit_q[cls_q] <= 3'(credit_q[cls_q] + 1'b1);
				end
			end
			if (cmd.finish && kind_q == KIND_SERVE && status_q == ST_RENEWED)
				for (int c = 0; c < NUM_CLASSES; c++) credit_q[c] <= '0;
		end
	end

	always_comb begin
		out_item.status       = status_q;
		out_item.served_valid = sv_q;
		out_item.served_id    = 32'(sid_q);
		out_item.served_class = sv_q ? cls_q : 2'd0;
	end
endmodule
`default_nettype wire

@@ hw/rtl/weighted_three_class_fifo_scheduler_unit.sv @@
// Top level of the weighted three-class FIFO scheduler.
// One transaction at a time: a command is accepted only in idle, then scans, shifts if
// needed, and presents its result. Insert and remove scan the selected queue one entry at
// a time for a duplicate or match, and a remove then moves each entry behind the removed id;
// a serve reads the head of the selected queue and compacts that queue. All queue work runs
// through the single registered read port of the shared queue memory, and the result is
// held while the output stalls. Queue memory needs no clearing; fill counts and credits
// reset to zero.
`default_nettype none
module weighted_three_class_fifo_scheduler_unit
	import wtcfs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_data,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	wtcfs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
	);

	wtcfs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_WIDTH(ID_WIDTH)) u_dp (
		.clk, .arst_n, .in_item(in_data), .cmd, .stat, .out_item(out_data),
		.cfg_we, .cfg_index, .cfg_data
	);
endmodule
`default_nettype wire

@@ bench/weighted_three_class_fifo_scheduler_unit_tb.sv @@
// Testbench for the weighted three-class FIFO scheduler: directed table, then random traffic.
`default_nettype none
module weighted_three_class_fifo_scheduler_unit_tb;
	import wtcfs_pkg::*;

	localparam int DEPTH = 16;
	localparam int LIMIT = 400000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	in_item_t in_data;
	out_item_t out_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	weighted_three_class_fifo_scheduler_unit #(.QUEUE_DEPTH(DEPTH), .ID_WIDTH(32)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] pq [3][DEPTH];
	int unsigned pfill [3];
	logic [2:0] pcredit [3];
	logic [7:0] p_upper, p_lower;
	logic [2:0] p_weight [3];

	out_item_t sched_expected [$];
	int errors = 0;
	int n_results = 0;
	int n_served = 0;
	int cycles = 0;
	int send_idle = 0, recv_stall = 0;
	logic [31:0] id_pool [8];

	typedef struct {
		in_item_t cmd;
		bit typed;
		out_item_t res;
	} dir_row_t;

	function automatic int unsigned class_of(logic [7:0] key);
		if (key > p_upper) return 0;
		if (key > p_lower) return 1;
		return 2;
	endfunction

	function automatic void drop_entry(int unsigned c, int unsigned pos);
		for (int unsigned i = pos; i + 1 < pfill[c]; i++) pq[c][i] = pq[c][i + 1];
		pfill[c]--;
	endfunction

	function automatic out_item_t sched_predict(in_item_t it);
		out_item_t r;
		int unsigned c;
		bit hit, done;
		r = '0;
		r.status = ST_OK;
		case (kind_t'(it.kind))
			KIND_INSERT: begin
				if (it.age_key == 0) r.status = ST_INVALID;
				else begin
					c = class_of(it.age_key);
					hit = 0;
					for (int unsigned i = 0; i < pfill[c]; i++)
						if (pq[c][i] == it.person_id) hit = 1;
					if (hit) r.status = ST_DUP;
					else if (pfill[c] >= DEPTH) r.status = ST_FULL;
					else begin
						pq[c][pfill[c]] = it.person_id;
						pfill[c]++;
					end
				end
			end
			KIND_SERVE: begin
				done = 0;
				for (int unsigned k = 0; k < 3 && !done; k++) begin
					if (pfill[k] != 0 && pcredit[k] < p_weight[k]) begin
						r.served_valid = 1;
						r.served_id = pq[k][0];
						r.served_class = k[1:0];
						drop_entry(k, 0);
						pcredit[k] = pcredit[k] + 3'd1;
						done = 1;
					end
				end
				if (!done) begin
					if (pfill[0] == 0 && pfill[1] == 0 && pfill[2] == 0) r.status = ST_EMPTY;
					else begin
						pcredit = '{3'd0, 3'd0, 3'd0};
						r.status = ST_RENEWED;
					end
				end
			end
			KIND_REMOVE: begin
				if (pfill[0] == 0 && pfill[1] == 0 && pfill[2] == 0) r.status = ST_EMPTY;
				else if (it.age_key == 0) r.status = ST_INVALID;
				else begin
					c = class_of(it.age_key);
					hit = 0;
					for (int unsigned i = 0; i < pfill[c] && !hit; i++)
						if (pq[c][i] == it.person_id) begin
							drop_entry(c, i);
							hit = 1;
						end
					if (!hit) r.status = ST_NOT_FOUND;
				end
			end
			default: r.status = ST_INVALID;
		endcase
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout at %0t", $time);
			$display("Verification failed");
			$finish;
		end
	end

	// result checking
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sched_expected.size() == 0) begin
				$display("%0t: unexpected transaction %p", $time, out_data);
				errors++;
			end else begin
				want = sched_expected.pop_front();
				n_results++;
				if (out_data.served_valid) n_served++;
				if (out_data.status !== want.status || out_data.served_valid !== want.served_valid
						|| out_data.served_id !== want.served_id
						|| out_data.served_class !== want.served_class) begin
					$display("%0t: mismatch expected %p actual %p", $time, want, out_data);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (recv_stall == 0) out_stall <= 0;
		else out_stall <= ($urandom_range(99) < recv_stall);
	end

	task automatic send(in_item_t it, bit typed, out_item_t res);
		out_item_t p;
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		p = sched_predict(it);
		if (typed && p != res) begin
			$display("%0t: table row expected %p predictor %p", $time, res, p);
			errors++;
		end
		sched_expected.push_back(p);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sched_expected.size() != 0) @(posedge clk);
		repeat (2 * DEPTH + 10) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [7:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_UPPER: p_upper = v;
			REG_LOWER: p_lower = v;
			REG_W0: p_weight[0] = v[2:0];
			REG_W1: p_weight[1] = v[2:0];
			default: p_weight[2] = v[2:0];
		endcase
		@(posedge clk);
	endtask

	function automatic in_item_t mk(kind_t k, logic [7:0] key, logic [31:0] id);
		in_item_t t;
		t.kind = k;
		t.age_key = key;
		t.person_id = id;
		return t;
	endfunction

	function automatic out_item_t st(status_t s);
		out_item_t r;
		r = '0;
		r.status = s;
		return r;
	endfunction

	function automatic logic [7:0] rand_key();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd255;
			2: return p_upper + 8'd1;
			3: return p_lower;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic in_item_t rand_item();
		int unsigned r;
		logic [31:0] id;
		r = $urandom_range(99);
		id = ($urandom_range(3) == 0) ? $urandom : id_pool[$urandom_range(7)];
		if (r < 45) return mk(KIND_INSERT, rand_key(), id);
		if (r < 80) return mk(KIND_SERVE, 8'($urandom), $urandom);
		if (r < 97) return mk(KIND_REMOVE, rand_key(), id);
		return mk(KIND_UNUSED, 8'($urandom), $urandom);
	endfunction

	initial begin
		dir_row_t dir_tab [$];
		out_item_t none;
		int phase;
		none = '0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		cfg_we = 0;
		cfg_index = REG_UPPER;
		cfg_data = '0;
		pfill = '{0, 0, 0};
		pcredit = '{3'd0, 3'd0, 3'd0};
		p_upper = 8'd55;
		p_lower = 8'd40;
		p_weight = '{3'd3, 3'd2, 3'd1};
		foreach (id_pool[i]) id_pool[i] = $urandom;
		id_pool[0] = 32'h0;
		id_pool[1] = 32'hFFFF_FFFF;

		dir_tab = '{
			'{mk(KIND_SERVE, 8'd0, 32'd0), 1, st(ST_EMPTY)},
			'{mk(KIND_REMOVE, 8'd0, 32'd0), 1, st(ST_EMPTY)},
			'{mk(KIND_INSERT, 8'd0, 32'd5), 1, st(ST_INVALID)},
			'{mk(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF), 1, st(ST_INVALID)},
			'{mk(KIND_INSERT, 8'd255, 32'hFFFF_FFFF), 1, st(ST_OK)},
			'{mk(KIND_INSERT, 8'd255, 32'hFFFF_FFFF), 1, st(ST_DUP)},
			'{mk(KIND_INSERT, 8'd56, 32'h0), 1, st(ST_OK)},
			'{mk(KIND_INSERT, 8'd55, 32'hAAAA_5555), 1, st(ST_OK)},
			'{mk(KIND_INSERT, 8'd41, 32'h5555_AAAA), 1, st(ST_OK)},
			'{mk(KIND_INSERT, 8'd40, 32'h1234_5678), 1, st(ST_OK)},
			'{mk(KIND_INSERT, 8'd1, 32'h8765_4321), 1, st(ST_OK)},
			'{mk(KIND_REMOVE, 8'd0, 32'h0), 1, st(ST_INVALID)},
			'{mk(KIND_REMOVE, 8'd100, 32'h7), 1, st(ST_NOT_FOUND)},
			'{mk(KIND_REMOVE, 8'd1, 32'h1234_5678), 1, st(ST_OK)},
			'{mk(KIND_SERVE, 8'd0, 32'd0), 0, none},
			'{mk(KIND_SERVE, 8'd0, 32'd0), 0, none},
			'{mk(KIND_SERVE, 8'd0, 32'd0), 0, none},
			'{mk(KIND_SERVE, 8'd0, 32'd0), 0, none},
			'{mk(KIND_SERVE, 8'd0, 32'd0), 0, none},
			'{mk(KIND_SERVE, 8'd0, 32'd0), 0, none},
			'{mk(KIND_SERVE, 8'd0, 32'd0), 0, none}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_tab[i]) send(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);
		// fill class two to capacity, then one more
		for (int i = 0; i <= DEPTH; i++) send(mk(KIND_INSERT, 8'd2, 32'(i + 100)), 0, none);
		send(mk(KIND_INSERT, 8'd2, 32'd100), 1, st(ST_DUP));
		drain();

		for (phase = 0; phase < 7; phase++) begin
			case (phase % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 83; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 83; end
				default: begin send_idle = 13; recv_stall = 13; end
			endcase
			case (phase)
				0: begin
					write_reg(REG_UPPER, 8'd255); write_reg(REG_LOWER, 8'd0);
					write_reg(REG_W0, 8'd7); write_reg(REG_W1, 8'd1); write_reg(REG_W2, 8'd0);
				end
				1: begin
					write_reg(REG_UPPER, 8'd0); write_reg(REG_LOWER, 8'd255);
					write_reg(REG_W0, 8'd1); write_reg(REG_W1, 8'd7); write_reg(REG_W2, 8'd7);
				end
				2: begin
					write_reg(REG_UPPER, 8'd30); write_reg(REG_LOWER, 8'd200);
					write_reg(REG_W0, 8'd0); write_reg(REG_W1, 8'd0); write_reg(REG_W2, 8'd2);
				end
				default: begin
					write_reg(REG_UPPER, 8'($urandom_range(255)));
					write_reg(REG_LOWER, 8'($urandom_range(255)));
					write_reg(REG_W0, 8'($urandom_range(7)));
					write_reg(REG_W1, 8'($urandom_range(7)));
					write_reg(REG_W2, 8'($urandom_range(7)));
				end
			endcase
			repeat (200) send(rand_item(), 0, none);
			drain();
		end

		$display("Covered %0d checked results, %0d of them serves, over seven register settings",
			n_results, n_served);
		$display("and four sender and receiver idling patterns.");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
